// ===== rtl/core/qte_pkg.sv =====
// qte_pkg: widths, constants and the cordic step angle function
// shared by the quaternion to euler angle pipeline; no dependencies
`default_nettype none

package qte_pkg;

	localparam int QW     = 16;
	localparam int PW     = 32;
	localparam int OP_W   = 34;
	localparam int CW     = 36;
	localparam int ANG_W  = 16;
	localparam int PIT_W  = 15;
	localparam int RAD_W  = 61;
	localparam int ROOT_W = 31;

	localparam int HALF_TURN    = 18000;
	localparam int QUARTER_TURN = 9000;

	localparam logic signed [OP_W-1:0] ONE_Q30 = OP_W'(64'd1 << 30);

	localparam logic [63:0] E12_PER_CDEG = 64'd10000000000;

	typedef struct packed {
		logic valid;
		logic clamp_hi;
		logic clamp_lo;
	} tag_t;

	function automatic logic [63:0] step_e12(input int i);
		logic [63:0] e;
		case (i)
			0:  e = 64'd45000000000000;
			1:  e = 64'd26565051177078;
			2:  e = 64'd14036243467926;
			3:  e = 64'd7125016348902;
			4:  e = 64'd3576334374997;
			5:  e = 64'd1789910608246;
			6:  e = 64'd895173710211;
			7:  e = 64'd447614170861;
			8:  e = 64'd223810500369;
			9:  e = 64'd111905677066;
			10: e = 64'd55952891894;
			11: e = 64'd27976452617;
			12: e = 64'd13988227142;
			13: e = 64'd6994113675;
			14: e = 64'd3497056851;
			15: e = 64'd1748528427;
			16: e = 64'd874264214;
			17: e = 64'd437132107;
			18: e = 64'd218566053;
			19: e = 64'd109283027;
			20: e = 64'd54641513;
			21: e = 64'd27320757;
			22: e = 64'd13660378;
			23: e = 64'd6830189;
			default: e = 64'd0;
		endcase
		return e;
	endfunction

	// atan(2^-i) in hundredths of a degree with frac fraction bits, rounded half up
	function automatic logic [63:0] step_angle(input int i, input int frac);
		logic [63:0] e;
		logic [63:0] q;
		logic [63:0] r;
		e = step_e12(i);
		q = e / E12_PER_CDEG;
		r = e % E12_PER_CDEG;
		return (q << frac) + (((r << frac) + (E12_PER_CDEG >> 1)) / E12_PER_CDEG);
	endfunction

endpackage

`default_nettype wire

// ===== rtl/core/qte_isqrt.sv =====
// qte_isqrt: pipelined restoring integer square root, one result bit per stage
// carries a side word and a valid bit alongside; depends on qte_pkg
`default_nettype none

module qte_isqrt #(
	parameter int SIDE_W = 1
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       en,
	input  wire logic                       vld_in,
	input  wire logic [qte_pkg::RAD_W-1:0]  rad,
	input  wire logic [SIDE_W-1:0]          side_in,
	output logic                            vld_out,
	output logic [qte_pkg::ROOT_W-1:0]      root,
	output logic [SIDE_W-1:0]               side_out
);

	localparam int STEPS = qte_pkg::ROOT_W;
	localparam int RW    = qte_pkg::RAD_W + 1;

	logic [RW-1:0]     rem_s  [1:STEPS];
	logic [RW-1:0]     res_s  [1:STEPS];
	logic [SIDE_W-1:0] side_s [1:STEPS];
	logic              vld_s  [1:STEPS];

	for (genvar k = 0; k < STEPS; k++) begin : g_step
		localparam logic [RW-1:0] BITV = RW'(1) << (2 * (STEPS - 1 - k));
		logic [RW-1:0]     cur_rem;
		logic [RW-1:0]     cur_res;
		logic [SIDE_W-1:0] cur_side;
		logic              cur_vld;
		logic [RW-1:0]     trial;

		if (k == 0) begin : g_first
			assign cur_rem  = RW'(rad);
			assign cur_res  = '0;
			assign cur_side = side_in;
			assign cur_vld  = vld_in;
		end else begin : g_next
			assign cur_rem  = rem_s[k];
			assign cur_res  = res_s[k];
			assign cur_side = side_s[k];
			assign cur_vld  = vld_s[k];
		end

		assign trial = cur_res + BITV;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else if (en) begin
				vld_s[k+1] <= cur_vld;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				side_s[k+1] <= cur_side;
				if (cur_rem >= trial) begin
					rem_s[k+1] <= cur_rem - trial;
					res_s[k+1] <= (cur_res >> 1) + BITV;
				end else begin
					rem_s[k+1] <= cur_rem;
					res_s[k+1] <= cur_res >> 1;
				end
			end
		end
	end

	assign vld_out  = vld_s[STEPS];
	assign root     = res_s[STEPS][qte_pkg::ROOT_W-1:0];
	assign side_out = side_s[STEPS];

endmodule

`default_nettype wire

// ===== rtl/core/qte_cordic.sv =====
// qte_cordic: pipelined vectoring cordic giving atan2 in hundredths of a degree
// pre-rotation stage, one stage per iteration, round and saturate stage; depends on qte_pkg
`default_nettype none

module qte_cordic #(
	parameter int CORDIC_STEPS = 16,
	parameter int FRAC_BITS    = 15,
	parameter int LIM          = 18000
) (
	input  wire logic                              clk,
	input  wire logic                              en,
	input  wire logic signed [qte_pkg::OP_W-1:0]   y_in,
	input  wire logic signed [qte_pkg::OP_W-1:0]   x_in,
	output logic signed [qte_pkg::ANG_W-1:0]       angle
);

	localparam int CW = qte_pkg::CW;
	localparam int ZW = FRAC_BITS + 17;
	localparam int RW = ZW - FRAC_BITS;

	localparam logic signed [ZW-1:0] QZ   = ZW'(qte_pkg::QUARTER_TURN) << FRAC_BITS;
	localparam logic signed [ZW-1:0] HALF = ZW'(1) << (FRAC_BITS - 1);
	localparam logic signed [RW-1:0] LIM_R = RW'(LIM);

	logic signed [CW-1:0] x_s    [0:CORDIC_STEPS];
	logic signed [CW-1:0] y_s    [0:CORDIC_STEPS];
	logic signed [ZW-1:0] z_s    [0:CORDIC_STEPS];
	logic                 zero_s [0:CORDIC_STEPS];

	logic signed [CW-1:0] xe;
	logic signed [CW-1:0] ye;

	assign xe = CW'(x_in);
	assign ye = CW'(y_in);

	always_ff @(posedge clk) begin
		if (en) begin
			zero_s[0] <= (xe == '0) && (ye == '0);
			if (xe < 0) begin
				if (ye >= 0) begin
					x_s[0] <= ye;
					y_s[0] <= -xe;
					z_s[0] <= QZ;
				end else begin
					x_s[0] <= -ye;
					y_s[0] <= xe;
					z_s[0] <= -QZ;
				end
			end else begin
				x_s[0] <= xe;
				y_s[0] <= ye;
				z_s[0] <= '0;
			end
		end
	end

	for (genvar i = 1; i <= CORDIC_STEPS; i++) begin : g_iter
		localparam int SH = i - 1;
		localparam logic signed [ZW-1:0] ANG = ZW'(qte_pkg::step_angle(SH, FRAC_BITS));
		logic signed [CW-1:0] xs;
		logic signed [CW-1:0] ys;

		assign xs = x_s[i-1] >>> SH;
		assign ys = y_s[i-1] >>> SH;

		always_ff @(posedge clk) begin
			if (en) begin
				zero_s[i] <= zero_s[i-1];
				if (y_s[i-1] > 0) begin
					x_s[i] <= x_s[i-1] + ys;
					y_s[i] <= y_s[i-1] - xs;
					z_s[i] <= z_s[i-1] + ANG;
				end else begin
					x_s[i] <= x_s[i-1] - ys;
					y_s[i] <= y_s[i-1] + xs;
					z_s[i] <= z_s[i-1] - ANG;
				end
			end
		end
	end

	logic signed [ZW-1:0] zr;
	logic signed [RW-1:0] rs;

	assign zr = z_s[CORDIC_STEPS] + HALF;
	assign rs = zr[ZW-1:FRAC_BITS];

	always_ff @(posedge clk) begin
		if (en) begin
			if (zero_s[CORDIC_STEPS]) begin
				angle <= '0;
			end else if (rs > LIM_R) begin
				angle <= qte_pkg::ANG_W'(LIM_R);
			end else if (rs < -LIM_R) begin
				angle <= qte_pkg::ANG_W'(-LIM_R);
			end else begin
				angle <= rs[qte_pkg::ANG_W-1:0];
			end
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/quaternion_to_euler_angles_top.sv =====
// quaternion_to_euler_angles_top: quaternion in Q1.15 to roll, pitch, yaw
// in hundredths of a degree; depends on qte_pkg, qte_isqrt, qte_cordic
//
// input channel: in_valid/in_stall with quat_x/y/z/w, one word per quaternion
// output channel: out_valid/out_stall with roll_angle, pitch_angle, yaw_angle
// and pitch_clamped, exactly one word out for every word in, in order
// stages: one product stage, one sum stage, one square stage, one radicand stage,
// 31 square root stages (one root bit each), then the cordic pre-rotation,
// CORDIC_STEPS iteration stages and a round and saturate stage, three cordics
// side by side
// throughput: one word per cycle while out_stall is low
// out_stall with out_valid high freezes the whole pipeline; in_stall is high exactly when a word
// waits at the output and out_stall is high, so nothing is lost or repeated
// reset clears all valid bits; the pipeline is empty and ready right after
// pitch is forced to +/-9000 and pitch_clamped set when |2(wy - zx)| >= 1
`default_nettype none

module quaternion_to_euler_angles_top #(
	parameter int CORDIC_STEPS = 16,
	parameter int FRAC_BITS    = 15
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              in_valid,
	output logic                                   in_stall,
	input  wire logic signed [qte_pkg::QW-1:0]     quat_x,
	input  wire logic signed [qte_pkg::QW-1:0]     quat_y,
	input  wire logic signed [qte_pkg::QW-1:0]     quat_z,
	input  wire logic signed [qte_pkg::QW-1:0]     quat_w,
	output logic                                   out_valid,
	input  wire logic                              out_stall,
	output logic signed [qte_pkg::ANG_W-1:0]       roll_angle,
	output logic signed [qte_pkg::PIT_W-1:0]       pitch_angle,
	output logic signed [qte_pkg::ANG_W-1:0]       yaw_angle,
	output logic                                   pitch_clamped
);

	localparam int PW   = qte_pkg::PW;
	localparam int OW   = qte_pkg::OP_W;
	localparam int CL   = CORDIC_STEPS + 2;
	localparam int SIDE = 5 * OW + 2;

	logic adv;
	assign adv      = !(out_valid && out_stall);
	assign in_stall = out_valid && out_stall;

	// products
	logic                 valid_s1;
	logic signed [PW-1:0] wx_s1, yz_s1, xx_s1, yy_s1, wy_s1, zx_s1, wz_s1, xy_s1, zz_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			wx_s1 <= quat_w * quat_x;
			yz_s1 <= quat_y * quat_z;
			xx_s1 <= quat_x * quat_x;
			yy_s1 <= quat_y * quat_y;
			wy_s1 <= quat_w * quat_y;
			zx_s1 <= quat_z * quat_x;
			wz_s1 <= quat_w * quat_z;
			xy_s1 <= quat_x * quat_y;
			zz_s1 <= quat_z * quat_z;
		end
	end

	// sine and cosine terms in Q.30
	logic                 valid_s2;
	logic signed [OW-1:0] sr_s2, cr_s2, sp_s2, sy_s2, cy_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sr_s2 <= (OW'(wx_s1) + OW'(yz_s1)) <<< 1;
			cr_s2 <= qte_pkg::ONE_Q30 - ((OW'(xx_s1) + OW'(yy_s1)) <<< 1);
			sp_s2 <= (OW'(wy_s1) - OW'(zx_s1)) <<< 1;
			sy_s2 <= (OW'(wz_s1) + OW'(xy_s1)) <<< 1;
			cy_s2 <= qte_pkg::ONE_Q30 - ((OW'(yy_s1) + OW'(zz_s1)) <<< 1);
		end
	end

	// pitch sine squared and clamp detection
	logic                 valid_s3;
	logic                 hi_s3, lo_s3;
	logic [59:0]          sq_s3;
	logic signed [OW-1:0] sr_s3, cr_s3, sp_s3, sy_s3, cy_s3;
	logic signed [OW-1:0] sp_abs;
	logic [29:0]          sp_mag;

	assign sp_abs = (sp_s2 < 0) ? -sp_s2 : sp_s2;
	assign sp_mag = sp_abs[29:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (adv) begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			hi_s3 <= sp_s2 >= qte_pkg::ONE_Q30;
			lo_s3 <= sp_s2 <= -qte_pkg::ONE_Q30;
			sq_s3 <= sp_mag * sp_mag;
			sr_s3 <= sr_s2;
			cr_s3 <= cr_s2;
			sp_s3 <= sp_s2;
			sy_s3 <= sy_s2;
			cy_s3 <= cy_s2;
		end
	end

	// radicand 1 - s^2
	logic                            valid_s4;
	logic [qte_pkg::RAD_W-1:0]       rad_s4;
	logic [SIDE-1:0]                 side_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
		end else if (adv) begin
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rad_s4  <= (qte_pkg::RAD_W'(1) << 60) - qte_pkg::RAD_W'(sq_s3);
			side_s4 <= {sr_s3, cr_s3, sp_s3, sy_s3, cy_s3, hi_s3, lo_s3};
		end
	end

	logic                         sq_valid;
	logic [qte_pkg::ROOT_W-1:0]   cp_root;
	logic [SIDE-1:0]              sq_side;

	qte_isqrt #(
		.SIDE_W(SIDE)
	) u_isqrt (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (adv),
		.vld_in  (valid_s4),
		.rad     (rad_s4),
		.side_in (side_s4),
		.vld_out (sq_valid),
		.root    (cp_root),
		.side_out(sq_side)
	);

	logic signed [OW-1:0] c_sr, c_cr, c_sp, c_sy, c_cy, c_cp;
	qte_pkg::tag_t        c_tag;

	assign {c_sr, c_cr, c_sp, c_sy, c_cy} = sq_side[SIDE-1:2];
	assign c_tag       = {sq_valid, sq_side[1:0]};
	assign c_cp        = OW'(cp_root);

	qte_pkg::tag_t tag_s [1:CL];

	for (genvar j = 1; j <= CL; j++) begin : g_tag
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				tag_s[j] <= '0;
			end else if (adv) begin
				tag_s[j] <= (j == 1) ? c_tag : tag_s[(j == 1) ? 1 : j - 1];
			end
		end
	end

	logic signed [qte_pkg::ANG_W-1:0] roll_w, pitch_w, yaw_w;

	qte_cordic #(
		.CORDIC_STEPS(CORDIC_STEPS),
		.FRAC_BITS   (FRAC_BITS),
		.LIM         (qte_pkg::HALF_TURN)
	) u_roll (
		.clk  (clk),
		.en   (adv),
		.y_in (c_sr),
		.x_in (c_cr),
		.angle(roll_w)
	);

	qte_cordic #(
		.CORDIC_STEPS(CORDIC_STEPS),
		.FRAC_BITS   (FRAC_BITS),
		.LIM         (qte_pkg::QUARTER_TURN)
	) u_pitch (
		.clk  (clk),
		.en   (adv),
		.y_in (c_sp),
		.x_in (c_cp),
		.angle(pitch_w)
	);

	qte_cordic #(
		.CORDIC_STEPS(CORDIC_STEPS),
		.FRAC_BITS   (FRAC_BITS),
		.LIM         (qte_pkg::HALF_TURN)
	) u_yaw (
		.clk  (clk),
		.en   (adv),
		.y_in (c_sy),
		.x_in (c_cy),
		.angle(yaw_w)
	);

	localparam logic signed [qte_pkg::PIT_W-1:0] PIT_MAX = qte_pkg::PIT_W'(qte_pkg::QUARTER_TURN);

	assign out_valid     = tag_s[CL].valid;
	assign roll_angle    = roll_w;
	assign yaw_angle     = yaw_w;
	assign pitch_clamped = tag_s[CL].clamp_hi || tag_s[CL].clamp_lo;
	assign pitch_angle   = tag_s[CL].clamp_hi ? PIT_MAX :
		tag_s[CL].clamp_lo ? -PIT_MAX : pitch_w[qte_pkg::PIT_W-1:0];

endmodule

`default_nettype wire

// ===== rtl/core/qte_checker.sv =====
// qte_checker: port level checks on quaternion_to_euler_angles_top
// bound to the top level below; depends on qte_pkg
`default_nettype none

module qte_checker (
	input wire logic                              clk,
	input wire logic                              arst_n,
	input wire logic                              in_stall,
	input wire logic                              out_valid,
	input wire logic                              out_stall,
	input wire logic signed [qte_pkg::ANG_W-1:0]  roll_angle,
	input wire logic signed [qte_pkg::PIT_W-1:0]  pitch_angle,
	input wire logic signed [qte_pkg::ANG_W-1:0]  yaw_angle,
	input wire logic                              pitch_clamped
);

	a_clamp_val: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && pitch_clamped |-> (pitch_angle == 15'sd9000 || pitch_angle == -15'sd9000))
		else $error("clamped pitch not at +/-9000");

	a_angle_rng: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (roll_angle <= 16'sd18000 && roll_angle >= -16'sd18000 &&
			yaw_angle <= 16'sd18000 && yaw_angle >= -16'sd18000 &&
			pitch_angle <= 15'sd9000 && pitch_angle >= -15'sd9000))
		else $error("angle out of range");

	a_bp_only_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled while output free");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(roll_angle) &&
			$stable(pitch_angle) && $stable(yaw_angle) && $stable(pitch_clamped))
		else $error("stalled output word changed");

endmodule

bind quaternion_to_euler_angles_top qte_checker u_qte_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_stall     (in_stall),
	.out_valid    (out_valid),
	.out_stall    (out_stall),
	.roll_angle   (roll_angle),
	.pitch_angle  (pitch_angle),
	.yaw_angle    (yaw_angle),
	.pitch_clamped(pitch_clamped)
);

`default_nettype wire
